// ----- src/pascal_subset_tokenizer_core_macros.svh -----
// assertion helpers for the tokenizer core
`ifndef PASCAL_SUBSET_TOKENIZER_CORE_MACROS_SVH
`define PASCAL_SUBSET_TOKENIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");
`else
`define PST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/pst_pkg.sv -----
package pst_pkg;

    // scanner modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_WORD    = 4'd1;
    localparam logic [3:0] M_NUM     = 4'd2;
    localparam logic [3:0] M_STR     = 4'd3;
    localparam logic [3:0] M_STRQ    = 4'd4;
    localparam logic [3:0] M_BRACE   = 4'd5;
    localparam logic [3:0] M_PAREN   = 4'd6;
    localparam logic [3:0] M_PCOM    = 4'd7;
    localparam logic [3:0] M_PSTAR   = 4'd8;
    localparam logic [3:0] M_COLON   = 4'd9;
    localparam logic [3:0] M_LESS    = 4'd10;
    localparam logic [3:0] M_GREATER = 4'd11;

    // token kinds
    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_ERROR  = 6'd1;
    localparam logic [5:0] K_IDENT  = 6'd2;
    localparam logic [5:0] K_INT    = 6'd3;
    localparam logic [5:0] K_STRING = 6'd4;
    localparam logic [5:0] K_SCHAR  = 6'd5;
    localparam logic [5:0] K_SEMI   = 6'd6;
    localparam logic [5:0] K_DOT    = 6'd7;
    localparam logic [5:0] K_COMMA  = 6'd8;
    localparam logic [5:0] K_LPAREN = 6'd9;
    localparam logic [5:0] K_RPAREN = 6'd10;
    localparam logic [5:0] K_PLUS   = 6'd11;
    localparam logic [5:0] K_MINUS  = 6'd12;
    localparam logic [5:0] K_STAR   = 6'd13;
    localparam logic [5:0] K_COLON  = 6'd14;
    localparam logic [5:0] K_ASSIGN = 6'd15;
    localparam logic [5:0] K_EQ     = 6'd16;
    localparam logic [5:0] K_NE     = 6'd17;
    localparam logic [5:0] K_LE     = 6'd18;
    localparam logic [5:0] K_LT     = 6'd19;
    localparam logic [5:0] K_GE     = 6'd20;
    localparam logic [5:0] K_GT     = 6'd21;
    localparam logic [5:0] K_KW0    = 6'd22;

    // error codes
    localparam logic [2:0] E_BRACE   = 3'd0;
    localparam logic [2:0] E_PCOM    = 3'd1;
    localparam logic [2:0] E_STR     = 3'd2;
    localparam logic [2:0] E_STRLONG = 3'd3;
    localparam logic [2:0] E_BYTE    = 3'd4;

    // source bytes with special meaning
    localparam logic [7:0] C_QUOTE  = 8'd39;
    localparam logic [7:0] C_LBRACE = 8'd123;
    localparam logic [7:0] C_RBRACE = 8'd125;
    localparam logic [7:0] C_LPAREN = 8'd40;
    localparam logic [7:0] C_RPAREN = 8'd41;
    localparam logic [7:0] C_STAR   = 8'd42;
    localparam logic [7:0] C_COLON  = 8'd58;
    localparam logic [7:0] C_LESS   = 8'd60;
    localparam logic [7:0] C_EQUAL  = 8'd61;
    localparam logic [7:0] C_GREAT  = 8'd62;
    localparam logic [7:0] C_NL     = 8'd10;

    localparam logic [15:0] SAT16 = 16'hFFFF;
    localparam logic [30:0] SAT31 = 31'h7FFFFFFF;

    localparam int KW_COUNT = 29;

    // keywords, first letter in the highest used byte
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        56'h70726f6772616d, 56'h766172, 56'h626567696e, 56'h656e64,
        56'h696e7465676572, 56'h646976, 56'h6d6f64, 56'h7772697465,
        56'h77726974656c6e, 56'h626f6f6c65616e, 56'h616e64, 56'h6f72,
        56'h6e6f74, 56'h74727565, 56'h66616c7365, 56'h6966, 56'h7468656e,
        56'h656c7365, 56'h7768696c65, 56'h646f, 56'h666f72, 56'h746f,
        56'h646f776e746f, 56'h726570656174, 56'h756e74696c, 56'h636f6e7374,
        56'h63686172, 56'h6f7264, 56'h636872
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd7, 3'd3, 3'd5, 3'd3, 3'd7, 3'd3, 3'd3, 3'd5, 3'd7, 3'd7, 3'd3, 3'd2,
        3'd3, 3'd4, 3'd5, 3'd2, 3'd4, 3'd4, 3'd5, 3'd2, 3'd3, 3'd2, 3'd6, 3'd6,
        3'd5, 3'd5, 3'd4, 3'd3, 3'd3
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [2:0]  err;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic [30:0] val;
        logic        last;
    } t_res;

    function automatic t_res mk_res(input logic [5:0] kind, input logic [2:0] err,
                                    input logic [15:0] line, input logic [15:0] col,
                                    input logic [15:0] len, input logic [30:0] val);
        t_res r;
        r.kind = kind;
        r.err  = err;
        r.line = line;
        r.col  = col;
        r.len  = len;
        r.val  = val;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// ----- src/pascal_subset_tokenizer_core.sv -----
// pascal subset tokenizer
// input channel (i_s_*): one source byte per beat in i_s_tdata[7:0]; i_s_tuser
//   set marks end of input, which flushes the pending token and emits END,
//   then the scanner returns to its reset state for a new text
// output channel (o_m_*): one token, error or decoded string char per beat;
//   o_m_tlast marks the last result caused by one input beat
// every input beat is scanned in the cycle it is accepted; its zero, one or two
//   results are written into a four-entry result queue at that clock edge and
//   are presented in order from the registered queue head
// throughput: one input beat per cycle while the queue has room for two
//   results; the output drains one result per cycle while i_m_tready is high,
//   so queue depth sets how long a run of two-result beats keeps full rate
// a stalled receiver fills the queue and then holds o_s_tready low; nothing
//   is dropped
// reset (synchronous, active low) empties the queue and returns line and
//   column to one with the scanner idle
module pascal_subset_tokenizer_core #(
    parameter int STRING_CAP = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // source_byte
    input  logic        i_s_tuser,   // end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // error_code[2:0], start_line[18:3], start_column[34:19],
    // lexeme_length[50:35], int_value[81:51], zero pad[87:82]
    output logic [87:0] o_m_tdata,
    output logic [5:0]  o_m_tuser,   // token_kind
    output logic        o_m_tlast    // last_of_run
);
    import pst_pkg::*;

    localparam logic [16:0] CAP = 17'(STRING_CAP);

    // scanner state
    logic [3:0]  r_mode,  n_mode;
    logic [15:0] r_line,  n_line;
    logic [15:0] r_col,   n_col;
    logic [15:0] r_tline, n_tline;
    logic [15:0] r_tcol,  n_tcol;
    logic [15:0] r_len,   n_len;
    logic [30:0] r_acc,   n_acc;
    logic [55:0] r_pref,  n_pref;

    // result queue
    t_res       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    logic [7:0] c;
    logic       is_blank, is_letter, is_num, acc_in, take_out;
    logic [7:0] folded;
    logic [5:0] word_kind;
    logic [34:0] num_next;

    // results of this beat: p1 is the pending token, p2 the new one
    logic p1_v, p2_v, do_sfi;
    t_res p1, p2, e0, e1;
    logic [1:0] nres;

    assign c         = i_s_tdata;
    assign acc_in    = i_s_tvalid && o_s_tready;
    assign take_out  = o_m_tvalid && i_m_tready;
    assign is_blank  = (c == 8'd32) || (c == 8'd9) || (c == 8'd13) || (c == 8'd10)
                    || (c == 8'd12) || (c == 8'd11);
    assign is_num    = (c >= 8'd48) && (c <= 8'd57);
    assign is_letter = ((c >= 8'd97) && (c <= 8'd122)) || ((c >= 8'd65) && (c <= 8'd90))
                    || (c == 8'd95);
    assign folded    = ((c >= 8'd65) && (c <= 8'd90)) ? c + 8'd32 : c;
    assign num_next  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + 35'(c - 8'd48);

    // keyword lookup on the folded prefix
    always_comb begin
        word_kind = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (r_len == 16'(KW_LEN[i]) && r_pref == KW_TEXT[i]) begin
                word_kind = K_KW0 + 6'(i);
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_len   = r_len;
        n_acc   = r_acc;
        n_pref  = r_pref;
        p1_v    = 1'b0;
        p2_v    = 1'b0;
        p1      = mk_res(K_END, 3'd0, r_tline, r_tcol, 16'd0, 31'd0);
        p2      = p1;
        do_sfi  = 1'b0;

        if (i_s_tuser) begin
            // flush whatever is pending, then END at the current position
            p1_v = 1'b1;
            case (r_mode)
                M_WORD:    p1 = mk_res(word_kind, 3'd0, r_tline, r_tcol, r_len, 31'd0);
                M_NUM:     p1 = mk_res(K_INT, 3'd0, r_tline, r_tcol, r_len, r_acc);
                M_STR:     p1 = mk_res(K_ERROR, E_STR, r_tline, r_tcol, 16'd0, 31'd0);
                M_STRQ:    p1 = mk_res(K_STRING, 3'd0, r_tline, r_tcol, r_len, 31'd0);
                M_BRACE:   p1 = mk_res(K_ERROR, E_BRACE, r_tline, r_tcol, 16'd0, 31'd0);
                M_PCOM,
                M_PSTAR:   p1 = mk_res(K_ERROR, E_PCOM, r_tline, r_tcol, 16'd0, 31'd0);
                M_PAREN:   p1 = mk_res(K_LPAREN, 3'd0, r_tline, r_tcol, 16'd1, 31'd0);
                M_COLON:   p1 = mk_res(K_COLON, 3'd0, r_tline, r_tcol, 16'd1, 31'd0);
                M_LESS:    p1 = mk_res(K_LT, 3'd0, r_tline, r_tcol, 16'd1, 31'd0);
                M_GREATER: p1 = mk_res(K_GT, 3'd0, r_tline, r_tcol, 16'd1, 31'd0);
                default:   p1_v = 1'b0;
            endcase
            p2_v    = 1'b1;
            p2      = mk_res(K_END, 3'd0, r_line, r_col, 16'd0, 31'd0);
            n_mode  = M_IDLE;
            n_line  = 16'd1;
            n_col   = 16'd1;
            n_tline = 16'd1;
            n_tcol  = 16'd1;
            n_len   = 16'd0;
            n_acc   = 31'd0;
            n_pref  = 56'd0;
        end else begin
            case (r_mode)
                M_WORD: begin
                    if (is_letter || is_num) begin
                        if (r_len < 16'd7) begin
                            n_pref = {r_pref[47:0], folded};
                        end
                        if (r_len != SAT16) begin
                            n_len = r_len + 16'd1;
                        end
                    end else begin
                        p1_v   = 1'b1;
                        p1     = mk_res(word_kind, 3'd0, r_tline, r_tcol, r_len, 31'd0);
                        do_sfi = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_num) begin
                        n_acc = (num_next > {4'd0, SAT31}) ? SAT31 : num_next[30:0];
                        if (r_len != SAT16) begin
                            n_len = r_len + 16'd1;
                        end
                    end else begin
                        p1_v   = 1'b1;
                        p1     = mk_res(K_INT, 3'd0, r_tline, r_tcol, r_len, r_acc);
                        do_sfi = 1'b1;
                    end
                end
                M_STR, M_STRQ: begin
                    if (r_mode == M_STR && c == C_QUOTE) begin
                        n_mode = M_STRQ;
                    end else if (r_mode == M_STR && c == C_NL) begin
                        p2_v   = 1'b1;
                        p2     = mk_res(K_ERROR, E_STR, r_tline, r_tcol, 16'd0, 31'd0);
                        n_mode = M_IDLE;
                    end else if (r_mode == M_STRQ && c != C_QUOTE) begin
                        p1_v   = 1'b1;
                        p1     = mk_res(K_STRING, 3'd0, r_tline, r_tcol, r_len, 31'd0);
                        do_sfi = 1'b1;
                    end else begin
                        // decoded string character, or too long
                        p2_v = 1'b1;
                        if ({1'b0, r_len} >= CAP) begin
                            p2     = mk_res(K_ERROR, E_STRLONG, r_tline, r_tcol,
                                            16'd0, 31'd0);
                            n_mode = M_IDLE;
                        end else begin
                            n_len  = r_len + 16'd1;
                            p2     = mk_res(K_SCHAR, 3'd0, r_tline, r_tcol,
                                            r_len + 16'd1, {23'd0, c});
                            n_mode = M_STR;
                        end
                    end
                end
                M_BRACE: begin
                    if (c == C_RBRACE) n_mode = M_IDLE;
                end
                M_PCOM: begin
                    if (c == C_STAR) n_mode = M_PSTAR;
                end
                M_PSTAR: begin
                    if (c == C_RPAREN) n_mode = M_IDLE;
                    else if (c != C_STAR) n_mode = M_PCOM;
                end
                M_PAREN: begin
                    if (c == C_STAR) begin
                        n_mode = M_PCOM;
                    end else begin
                        p1_v   = 1'b1;
                        p1     = mk_res(K_LPAREN, 3'd0, r_tline, r_tcol, 16'd1, 31'd0);
                        do_sfi = 1'b1;
                    end
                end
                M_COLON: begin
                    p1_v = 1'b1;
                    if (c == C_EQUAL) begin
                        p1     = mk_res(K_ASSIGN, 3'd0, r_tline, r_tcol, 16'd2, 31'd0);
                        n_mode = M_IDLE;
                    end else begin
                        p1     = mk_res(K_COLON, 3'd0, r_tline, r_tcol, 16'd1, 31'd0);
                        do_sfi = 1'b1;
                    end
                end
                M_LESS: begin
                    p1_v = 1'b1;
                    if (c == C_GREAT) begin
                        p1     = mk_res(K_NE, 3'd0, r_tline, r_tcol, 16'd2, 31'd0);
                        n_mode = M_IDLE;
                    end else if (c == C_EQUAL) begin
                        p1     = mk_res(K_LE, 3'd0, r_tline, r_tcol, 16'd2, 31'd0);
                        n_mode = M_IDLE;
                    end else begin
                        p1     = mk_res(K_LT, 3'd0, r_tline, r_tcol, 16'd1, 31'd0);
                        do_sfi = 1'b1;
                    end
                end
                M_GREATER: begin
                    p1_v = 1'b1;
                    if (c == C_EQUAL) begin
                        p1     = mk_res(K_GE, 3'd0, r_tline, r_tcol, 16'd2, 31'd0);
                        n_mode = M_IDLE;
                    end else begin
                        p1     = mk_res(K_GT, 3'd0, r_tline, r_tcol, 16'd1, 31'd0);
                        do_sfi = 1'b1;
                    end
                end
                default: do_sfi = 1'b1;
            endcase

            // start a new token from idle on this byte
            if (do_sfi) begin
                n_mode = M_IDLE;
                if (!is_blank) begin
                    n_tline = r_line;
                    n_tcol  = r_col;
                    if (is_letter) begin
                        n_len  = 16'd1;
                        n_pref = {48'd0, folded};
                        n_mode = M_WORD;
                    end else if (is_num) begin
                        n_len  = 16'd1;
                        n_acc  = 31'(c - 8'd48);
                        n_mode = M_NUM;
                    end else begin
                        p2_v = 1'b1;
                        p2   = mk_res(K_ERROR, 3'd0, r_line, r_col, 16'd1, 31'd0);
                        case (c)
                            C_QUOTE:  begin n_len = 16'd0; n_mode = M_STR; p2_v = 1'b0; end
                            C_LBRACE: begin n_mode = M_BRACE;   p2_v = 1'b0; end
                            C_LPAREN: begin n_mode = M_PAREN;   p2_v = 1'b0; end
                            C_COLON:  begin n_mode = M_COLON;   p2_v = 1'b0; end
                            C_LESS:   begin n_mode = M_LESS;    p2_v = 1'b0; end
                            C_GREAT:  begin n_mode = M_GREATER; p2_v = 1'b0; end
                            8'd59:    p2.kind = K_SEMI;
                            8'd46:    p2.kind = K_DOT;
                            8'd44:    p2.kind = K_COMMA;
                            C_RPAREN: p2.kind = K_RPAREN;
                            8'd43:    p2.kind = K_PLUS;
                            8'd45:    p2.kind = K_MINUS;
                            C_STAR:   p2.kind = K_STAR;
                            C_EQUAL:  p2.kind = K_EQ;
                            default: begin
                                p2.err = E_BYTE;
                                p2.len = 16'd0;
                            end
                        endcase
                    end
                end
            end

            // position of the next byte
            if (c == C_NL) begin
                if (r_line != SAT16) n_line = r_line + 16'd1;
                n_col = 16'd1;
            end else if (r_col != SAT16) begin
                n_col = r_col + 16'd1;
            end
        end

        // order the results and mark the last one of the beat
        e0   = p1_v ? p1 : p2;
        e1   = p2;
        nres = 2'(p1_v) + 2'(p2_v);
        if (nres == 2'd1) e0.last = 1'b1;
        e1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= 16'd1;
            r_col   <= 16'd1;
            r_tline <= 16'd1;
            r_tcol  <= 16'd1;
            r_len   <= 16'd0;
            r_acc   <= 31'd0;
            r_pref  <= 56'd0;
        end else if (acc_in) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_pref  <= n_pref;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (acc_in && nres != 2'd0) begin
            r_q[r_wp] <= e0;
            if (nres == 2'd2) r_q[r_wp + 2'd1] <= e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (acc_in) r_wp <= r_wp + nres;
            if (take_out) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + (acc_in ? {1'b0, nres} : 3'd0) - (take_out ? 3'd1 : 3'd0);
        end
    end

    assign o_s_tready = (r_cnt <= 3'd2);
    assign o_m_tvalid = (r_cnt != 3'd0);
    assign o_m_tuser  = r_q[r_rp].kind;
    assign o_m_tlast  = r_q[r_rp].last;
    assign o_m_tdata  = {6'd0, r_q[r_rp].val, r_q[r_rp].len, r_q[r_rp].col,
                         r_q[r_rp].line, r_q[r_rp].err};

`include "pascal_subset_tokenizer_core_macros.svh"

    `PST_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd4)
    `PST_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, acc_in && i_s_tuser,
                     r_mode == M_IDLE && r_line == 16'd1 && r_col == 16'd1 && r_cnt != 3'd0)
    `PST_ASSERT_NEXT(a_drain_only, i_clk, i_rst_n, take_out && !acc_in,
                     r_cnt == $past(r_cnt) - 3'd1)
    `PST_ASSERT_IMPL(a_str_len_cap, i_clk, i_rst_n, r_mode == M_STR,
                     {1'b0, r_len} <= CAP)

endmodule
